/* sv/cvsc_pkg.sv */
// ----------------------------------------------------------------------------
// cvsc_pkg
// Types, widths and register codes shared by the video sample conditioner.
// ----------------------------------------------------------------------------
package cvsc_pkg;

  localparam int SampleW   = 6;
  localparam int Q8W       = 14;
  localparam int CodeW     = 8;
  localparam int LowW      = 6;
  localparam int GainW     = 16;
  localparam int ShiftW    = 4;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;
  localparam int TargetW   = 25;

  localparam logic [Q8W-1:0]    DcBiasReset  = '0;
  localparam logic [CodeW-1:0]  BlackReset   = '0;
  localparam logic [GainW-1:0]  GainReset    = 16'd256;
  localparam logic [ShiftW-1:0] ShiftReset   = '0;
  localparam logic [CodeW-1:0]  FloorReset   = '0;
  localparam logic [CodeW-1:0]  CeilingReset = 8'd255;
  localparam logic [LowW-1:0]   LowStart     = 6'd63;
  localparam logic [CodeW-1:0]  HighStart    = 8'd0;
  localparam logic [8:0]        RoundHalf    = 9'd128;

  typedef enum logic [CfgIndexW-1:0] {
    REG_DC_BIAS      = 3'd0,
    REG_BLACK_LEVEL  = 3'd1,
    REG_INVERT       = 3'd2,
    REG_GAIN         = 3'd3,
    REG_SMOOTH_SHIFT = 3'd4,
    REG_CODE_FLOOR   = 3'd5,
    REG_CODE_CEILING = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0] video_code;
    logic [LowW-1:0]  block_low;
    logic [CodeW-1:0] block_high;
    logic             block_done;
  } out_item_t;

  typedef struct packed {
    logic [Q8W-1:0]    dc_bias;
    logic [CodeW-1:0]  black_level;
    logic              invert_enable;
    logic [GainW-1:0]  gain;
    logic [ShiftW-1:0] smooth_shift;
    logic [CodeW-1:0]  code_floor;
    logic [CodeW-1:0]  code_ceiling;
  } cfg_t;

  typedef struct packed {
    logic signed [TargetW-1:0] target;
    logic                      end_of_block;
  } mid_item_t;

endpackage

/* sv/composite_video_sample_conditioner.sv */
// ----------------------------------------------------------------------------
// composite_video_sample_conditioner
// Turns 6-bit phase-delta samples into clamped 8-bit composite video codes.
// ----------------------------------------------------------------------------
// Input items (sample, end_of_block) enter on in_valid/in_ready; result items
// (video_code, block_low, block_high, block_done) leave on out_valid/out_ready.
// One result item per input item, in order.
// An accepted item passes through the input, middle and output registers
// before it is presented on out_valid.
// Throughput: one item per cycle unless the receiver stalls; the front-stage DC
// tracker loop and back-stage smoothing accumulator loop do not limit it.
// Each stage holds its item while the next is full, so a stalled receiver
// backs up through the output, middle and input registers before in_ready
// drops; the block still takes items while a result waits if a stage is free.
// Reset restores register defaults, primes the tracker and accumulator, and
// starts the block minimum at 63 and maximum at 0. A write to a valid register
// index re-primes tracker and accumulator on the next cycle; write only when idle.
// ----------------------------------------------------------------------------
module composite_video_sample_conditioner (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  cvsc_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output cvsc_pkg::out_item_t                out_item,
  input  logic                               cfg_we,
  input  logic [cvsc_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [cvsc_pkg::CfgDataW-1:0]      cfg_data
);
  import cvsc_pkg::*;

  cfg_t      cfg;
  logic      prime;
  logic      mid_valid;
  logic      mid_ready;
  mid_item_t mid_item;

  cvsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .prime     (prime)
  );

  cvsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .prime     (prime),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_item  (mid_item)
  );

  cvsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .prime     (prime),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_item  (mid_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* sv/cvsc_cfg.sv */
// ----------------------------------------------------------------------------
// cvsc_cfg
// Configuration register file; flags a re-prime after every valid write.
// ----------------------------------------------------------------------------
module cvsc_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [cvsc_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [cvsc_pkg::CfgDataW-1:0]      cfg_data,
  output cvsc_pkg::cfg_t                     cfg,
  output logic                               prime
);
  import cvsc_pkg::*;

  logic valid_index;

  always_comb begin
    unique case (cfg_index)
      REG_DC_BIAS, REG_BLACK_LEVEL, REG_INVERT, REG_GAIN,
      REG_SMOOTH_SHIFT, REG_CODE_FLOOR, REG_CODE_CEILING: valid_index = 1'b1;
      default: valid_index = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dc_bias       <= DcBiasReset;
      cfg.black_level   <= BlackReset;
      cfg.invert_enable <= 1'b0;
      cfg.gain          <= GainReset;
      cfg.smooth_shift  <= ShiftReset;
      cfg.code_floor    <= FloorReset;
      cfg.code_ceiling  <= CeilingReset;
      prime             <= 1'b0;
    end else begin
      prime <= cfg_we && valid_index;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DC_BIAS:      cfg.dc_bias       <= cfg_data[Q8W-1:0];
          REG_BLACK_LEVEL:  cfg.black_level   <= cfg_data[CodeW-1:0];
          REG_INVERT:       cfg.invert_enable <= cfg_data[0];
          REG_GAIN:         cfg.gain          <= cfg_data[GainW-1:0];
          REG_SMOOTH_SHIFT: cfg.smooth_shift  <= cfg_data[ShiftW-1:0];
          REG_CODE_FLOOR:   cfg.code_floor    <= cfg_data[CodeW-1:0];
          REG_CODE_CEILING: cfg.code_ceiling  <= cfg_data[CodeW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* sv/cvsc_front.sv */
// ----------------------------------------------------------------------------
// cvsc_front
// Input register, DC tracker, centring, inversion, Q8 gain and black-level offset.
// ----------------------------------------------------------------------------
module cvsc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  cvsc_pkg::cfg_t        cfg,
  input  logic                  prime,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cvsc_pkg::in_item_t    in_item,
  output logic                  mid_valid,
  input  logic                  mid_ready,
  output cvsc_pkg::mid_item_t   mid_item
);
  import cvsc_pkg::*;

  logic                        s1_valid;
  in_item_t                    s1_item;
  logic [Q8W-1:0]              dc_track;
  logic [Q8W-1:0]              dc_next;
  logic [Q8W-1:0]              in_q8;
  logic                        mid_adv;
  logic signed [Q8W:0]         centred;
  logic signed [Q8W:0]         centred_sel;
  logic signed [GainW:0]       gain_s;
  logic signed [31:0]          product;
  logic signed [TargetW-1:0]   target;

  assign mid_adv  = s1_valid && (!mid_valid || mid_ready);
  assign in_ready = !s1_valid || mid_adv;

  always_comb begin
    in_q8       = {s1_item.sample, 8'b0};
    dc_next     = dc_track - {{(Q8W-1){1'b0}}, (in_q8 < dc_track)};
    centred     = $signed({1'b0, in_q8}) - $signed({1'b0, dc_next});
    centred_sel = cfg.invert_enable ? -centred : centred;
    gain_s      = $signed({1'b0, cfg.gain});
    product     = 32'(centred_sel) * 32'(gain_s);
    target      = $signed({9'b0, cfg.black_level, 8'b0})
                + $signed({product[31], product[31:8]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      mid_valid <= 1'b0;
      dc_track  <= DcBiasReset;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (mid_adv) begin
        s1_valid <= 1'b0;
      end
      if (mid_adv) begin
        mid_valid <= 1'b1;
      end else if (mid_ready) begin
        mid_valid <= 1'b0;
      end
      if (prime) begin
        dc_track <= cfg.dc_bias;
      end else if (mid_adv) begin
        dc_track <= dc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
    if (mid_adv) begin
      mid_item.target       <= target;
      mid_item.end_of_block <= s1_item.end_of_block;
    end
  end

endmodule

/* sv/cvsc_back.sv */
// ----------------------------------------------------------------------------
// cvsc_back
// IIR smoothing, rounding, clamping and running block minimum and maximum.
// ----------------------------------------------------------------------------
module cvsc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  cvsc_pkg::cfg_t        cfg,
  input  logic                  prime,
  input  logic                  mid_valid,
  output logic                  mid_ready,
  input  cvsc_pkg::mid_item_t   mid_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cvsc_pkg::out_item_t   out_item
);
  import cvsc_pkg::*;

  logic signed [TargetW-1:0]   smooth_acc;
  logic signed [TargetW-1:0]   acc_next;
  logic signed [TargetW:0]     diff;
  logic signed [TargetW:0]     step;
  logic signed [TargetW-1:0]   filtered;
  logic signed [TargetW:0]     rounded;
  logic signed [TargetW-8:0]   code;
  logic [CodeW-1:0]            code_c;
  logic [LowW-1:0]             run_low;
  logic [CodeW-1:0]            run_high;
  logic [LowW-1:0]             low_next;
  logic [CodeW-1:0]            high_next;
  logic                        out_adv;
  logic                        filter_on;

  assign mid_ready = !out_valid || out_ready;
  assign out_adv   = mid_valid && mid_ready;
  assign filter_on = (cfg.smooth_shift != '0);

  always_comb begin
    diff     = {mid_item.target[TargetW-1], mid_item.target}
             - {smooth_acc[TargetW-1], smooth_acc};
    step     = diff >>> cfg.smooth_shift;
    acc_next = smooth_acc + step[TargetW-1:0];
    filtered = filter_on ? acc_next : mid_item.target;
    rounded  = {filtered[TargetW-1], filtered} + $signed({{(TargetW-8){1'b0}}, RoundHalf});
    code     = rounded[TargetW:8];
    if (code < $signed({{(TargetW-CodeW-7){1'b0}}, cfg.code_floor})) begin
      code_c = cfg.code_floor;
    end else if (code > $signed({{(TargetW-CodeW-7){1'b0}}, cfg.code_ceiling})) begin
      code_c = cfg.code_ceiling;
    end else begin
      code_c = code[CodeW-1:0];
    end
    low_next  = (code_c < {2'b0, run_low}) ? code_c[LowW-1:0] : run_low;
    high_next = (code_c > run_high) ? code_c : run_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      smooth_acc <= $signed({9'b0, BlackReset, 8'b0});
      run_low    <= LowStart;
      run_high   <= HighStart;
    end else begin
      if (out_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (prime) begin
        smooth_acc <= $signed({9'b0, cfg.black_level, 8'b0});
      end else if (out_adv && filter_on) begin
        smooth_acc <= acc_next;
      end
      if (out_adv) begin
        run_low  <= mid_item.end_of_block ? LowStart : low_next;
        run_high <= mid_item.end_of_block ? HighStart : high_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_item.video_code <= code_c;
      out_item.block_low  <= low_next;
      out_item.block_high <= high_next;
      out_item.block_done <= mid_item.end_of_block;
    end
  end

endmodule
